// File: rtl/stmf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stmf_pkg
// Shared types and fixed constants of the sliding trimmed-mean filter.
// ----------------------------------------------------------------------------
package stmf_pkg;

  // Sample format: signed 16-bit fixed point.
  localparam int SAMPLE_W = 16;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage : stmf_pkg
`default_nettype wire

// File: rtl/stmf_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stmf_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module stmf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : stmf_ram
`default_nettype wire

// File: rtl/stmf_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stmf_div
// Floor division of a signed sum by a constant through a reciprocal multiply,
// biased sum then product registered. The result is valid while done is high.
// ----------------------------------------------------------------------------
module stmf_div #(
  parameter int DIVISOR = 8,
  parameter int SUM_W   = 19
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] dividend,
  output logic                    done,
  output stmf_pkg::sample_t       quotient
);
  import stmf_pkg::*;

  // Bias the sum by DIVISOR * 2**15 so it is never negative. The floor
  // quotient of the biased sum is then offset by 2**15, which flipping its
  // top bit removes. The reciprocal is rounded up and exact for every
  // SUM_W-bit unsigned value.
  localparam int     DIV_W   = $clog2(DIVISOR);
  localparam int     SHIFT   = SUM_W + DIV_W;
  localparam int     RECIP_W = SUM_W + 1;
  localparam int     PROD_W  = SUM_W + RECIP_W;
  localparam longint RECIP   =
    ((longint'(1) << SHIFT) + longint'(DIVISOR) - longint'(1)) / longint'(DIVISOR);
  localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);
  localparam logic [SUM_W-1:0]   BIAS    = SUM_W'(longint'(DIVISOR) << (SAMPLE_W - 1));

  logic                stage1;
  logic [SUM_W-1:0]    biased;
  logic [PROD_W-1:0]   prod;
  logic [SAMPLE_W-1:0] q;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage1 <= 1'b0;
      done   <= 1'b0;
    end else begin
      stage1 <= start;
      done   <= stage1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      biased <= $unsigned(dividend) + BIAS;
    end
    if (stage1) begin
      prod <= PROD_W'(biased) * PROD_W'(RECIP_V);
    end
  end

  assign q        = prod[SHIFT +: SAMPLE_W];
  assign quotient = sample_t'({~q[SAMPLE_W-1], q[SAMPLE_W-2:0]});

endmodule : stmf_div
`default_nettype wire

// File: rtl/sliding_trimmed_mean_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_trimmed_mean_filter
// Sliding-window filter: median of the samples so far while the window
// fills, then the floor mean of the KEEP central samples of the window.
// ----------------------------------------------------------------------------
// Each accepted item is one signed 16-bit sample; each item gives exactly one
// result. Until WINDOW samples have arrived the result is the median (element
// k/2 of the sorted first k+1 samples) with window_full low; from then on each
// sample replaces the oldest one and the result is the floor mean of the KEEP
// central sorted samples, with window_full high. Two RAMs hold the state: one
// keeps samples in arrival order, the other keeps the window sorted. Per item
// one streaming pass reads the sorted RAM, drops the oldest sample, merges the
// new one in and writes it back. The full-window mean then goes through a
// reciprocal multiply that floor-divides the sum by the clamped KEEP. A new
// sample is accepted only once the previous item's result has reached the
// output register. A finished result waits in the output register and does
// not stop the next item from being accepted. No clearing pass is needed
// after reset.
// ----------------------------------------------------------------------------
module sliding_trimmed_mean_filter #(
  parameter int WINDOW = 16,
  parameter int KEEP   = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  stmf_pkg::sample_t  sample,
  output logic               out_valid,
  input  logic               out_ready,
  output stmf_pkg::sample_t  filtered,
  output logic               window_full
);
  import stmf_pkg::*;

  // Effective trimmed count, clamped to the window, and its sorted start.
  localparam int EK    = (KEEP > WINDOW) ? WINDOW : KEEP;
  localparam int START = (WINDOW - EK) / 2;
  localparam int AW    = $clog2(WINDOW);
  localparam int CW    = $clog2(WINDOW + 2);
  localparam int SUM_W = SAMPLE_W + $clog2(EK);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MERGE  = 3'd1;
  localparam logic [2:0] S_DSTART = 3'd2;
  localparam logic [2:0] S_DWAIT  = 3'd3;
  localparam logic [2:0] S_RES    = 3'd4;

  logic [2:0]              state;
  logic [CW-1:0]           t;          // pass cycle counter
  logic [AW-1:0]           pos;        // next arrival slot to write
  logic                    filled;
  logic                    rem_flag;   // oldest sample already dropped
  logic                    ins_flag;   // new sample already merged in

  logic                    full_now;
  sample_t                 nv;         // new sample of the current item
  sample_t                 old_val;    // oldest sample, to be dropped
  sample_t                 prev;
  sample_t                 cur;
  logic signed [SUM_W-1:0] acc;
  sample_t                 res;

  sample_t                 rd_arrival;
  sample_t                 rd_sorted;
  logic [SAMPLE_W-1:0]     rd_arrival_raw;
  logic [SAMPLE_W-1:0]     rd_sorted_raw;

  logic                    step_valid;
  logic [CW-1:0]           j;
  logic [CW-1:0]           n_u;
  logic                    has_j;
  logic                    step_last;
  logic                    rem_here;
  logic                    ins_here;
  sample_t                 u_j;
  sample_t                 u_jm1;
  sample_t                 t_val;
  logic                    sum_en;
  logic                    med_en;

  logic                    div_done;
  sample_t                 div_quot;

  assign in_ready = (state == S_IDLE);

  // --------------------------------------------------------------------------
  // Arrival-order store: read the oldest slot on accept, overwrite it with
  // the new sample in the first pass cycle.
  // --------------------------------------------------------------------------
  stmf_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW)
  ) u_arrival_ram (
    .clk   (clk),
    .we    ((state == S_MERGE) && (t == '0)),
    .waddr (pos),
    .wdata (nv),
    .raddr (pos),
    .rdata (rd_arrival_raw)
  );
  assign rd_arrival = sample_t'(rd_arrival_raw);

  // --------------------------------------------------------------------------
  // Sorted store: read entry t each cycle, write back entry t-2. The write
  // trails the read by two entries, so a sorted entry is never overwritten
  // before it has been read.
  // --------------------------------------------------------------------------
  stmf_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW)
  ) u_sorted_ram (
    .clk   (clk),
    .we    (step_valid),
    .waddr (j[AW-1:0]),
    .wdata (t_val),
    .raddr (t[AW-1:0]),
    .rdata (rd_sorted_raw)
  );
  assign rd_sorted = sample_t'(rd_sorted_raw);

  // --------------------------------------------------------------------------
  // Merge step j: prev, cur and rd_sorted hold sorted entries j-1, j, j+1.
  // U is the old list with the oldest sample dropped; the new list takes
  // U[j] until the new sample fits, then the new sample, then U[j-1].
  // --------------------------------------------------------------------------
  assign step_valid = (state == S_MERGE) && (t >= CW'(2));
  assign j          = t - CW'(2);
  assign n_u        = full_now ? CW'(WINDOW - 1) : CW'(pos);
  assign has_j      = j < n_u;
  assign step_last  = step_valid && (j == n_u);

  assign rem_here = full_now && !rem_flag && (cur == old_val);
  assign u_j      = (rem_flag || rem_here) ? rd_sorted : cur;
  assign u_jm1    = rem_flag ? cur : prev;

  always_comb begin
    ins_here = 1'b0;
    if (ins_flag) begin
      t_val = u_jm1;
    end else if (has_j && (u_j < nv)) begin
      t_val = u_j;
    end else begin
      t_val    = nv;
      ins_here = 1'b1;
    end
  end

  // Pick the median in fill phase, sum the central span once full.
  assign med_en = step_valid && !full_now && (j == CW'(pos >> 1));
  assign sum_en = step_valid && full_now &&
                  (j >= CW'(START)) && (j < CW'(START + EK));

  stmf_div #(
    .DIVISOR (EK),
    .SUM_W   (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_DSTART),
    .dividend (acc),
    .done     (div_done),
    .quotient (div_quot)
  );

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      t         <= '0;
      pos       <= '0;
      filled    <= 1'b0;
      rem_flag  <= 1'b0;
      ins_flag  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Drop the held result once taken; a new one below overrides.
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            t        <= '0;
            rem_flag <= 1'b0;
            ins_flag <= 1'b0;
            state    <= S_MERGE;
          end
        end
        S_MERGE: begin
          t <= t + CW'(1);
          if (step_valid) begin
            rem_flag <= rem_flag | rem_here;
            ins_flag <= ins_flag | ins_here;
          end
          if (step_last) begin
            // Advance the arrival slot; mark the window full after the last
            // fill slot.
            pos <= (pos == AW'(WINDOW - 1)) ? '0 : pos + AW'(1);
            if (pos == AW'(WINDOW - 1)) begin
              filled <= 1'b1;
            end
            state <= full_now ? S_DSTART : S_RES;
          end
        end
        S_DSTART: begin
          state <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_done) begin
            state <= S_RES;
          end
        end
        S_RES: begin
          // Hold until the output register is free.
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      nv       <= sample;
      full_now <= filled;
      acc      <= '0;
    end
    if (state == S_MERGE) begin
      prev <= cur;
      cur  <= rd_sorted;
      if (t == '0) begin
        old_val <= rd_arrival;
      end
      if (sum_en) begin
        acc <= acc + SUM_W'(t_val);
      end
      if (med_en) begin
        res <= t_val;
      end
    end
    if (state == S_DWAIT && div_done) begin
      res <= div_quot;
    end
    if (state == S_RES && (!out_valid || out_ready)) begin
      filtered    <= res;
      window_full <= full_now;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_oldest_dropped: assert property (@(posedge clk) disable iff (rst)
    (step_last && full_now) |-> (rem_flag || rem_here))
    else $error("oldest sample not found in sorted store");

  a_new_merged: assert property (@(posedge clk) disable iff (rst)
    step_last |-> (ins_flag || ins_here))
    else $error("new sample not merged by end of pass");

  a_div_owned: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DWAIT))
    else $error("divider finished outside its wait state");

  a_filled_sticky: assert property (@(posedge clk) disable iff (rst)
    filled |=> filled)
    else $error("window full flag fell");

endmodule : sliding_trimmed_mean_filter
`default_nettype wire
